// File: rtl/core/rgbtc_pkg.sv
// shared constants and types for the hue preserving tone curve block
package rgbtc_pkg;
    localparam int unsigned TableDepthDefault = 65536;
    localparam int unsigned ChWidth = 18;
    localparam int unsigned ValWidth = 16;
    localparam int unsigned QuotWidth = 16;
    localparam logic ReqPixel = 1'b0;
    localparam logic ReqWrite = 1'b1;

    // channel roles after ordering
    typedef struct packed {
        logic [1:0] hi_sel;
        logic [1:0] mid_sel;
        logic [1:0] lo_sel;
        logic       direct;
    } order_t;

    typedef struct packed {
        logic signed [ChWidth-1:0] red;
        logic signed [ChWidth-1:0] green;
        logic signed [ChWidth-1:0] blue;
    } rgb_t;
endpackage

// File: rtl/core/rgbtc_div.sv
// pipelined restoring divider, one quotient bit per stage
module rgbtc_div (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [31:0]                        num,
    input  logic [rgbtc_pkg::ValWidth-1:0]     den,
    output logic [rgbtc_pkg::QuotWidth-1:0]    quot
);
    import rgbtc_pkg::*;
    localparam int unsigned Steps = QuotWidth;

    logic [31:0]         rem_reg [0:Steps];
    logic [ValWidth-1:0] den_reg [0:Steps];
    logic [QuotWidth-1:0] q_reg  [0:Steps];

    always_comb begin
        rem_reg[0] = num;
        den_reg[0] = den;
        q_reg[0]   = '0;
    end

    // quotient is known below 2^16 since num < den * 65536
    for (genvar i = 0; i < Steps; i++) begin : g_step
        logic [32:0] trial;
        logic [31:0] shifted_den;
        assign shifted_den = {16'd0, den_reg[i]} << (Steps - 1 - i);
        assign trial = {1'b0, rem_reg[i]} - {1'b0, shifted_den};
        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[i+1] <= den_reg[i];
                if (!trial[32]) begin
                    rem_reg[i+1] <= trial[31:0];
                    q_reg[i+1]   <= q_reg[i] | (QuotWidth'(1) << (Steps - 1 - i));
                end else begin
                    rem_reg[i+1] <= rem_reg[i];
                    q_reg[i+1]   <= q_reg[i];
                end
            end
        end
    end

    assign quot = q_reg[Steps];
endmodule

// File: rtl/core/rgb_tone_curve_hue_preserving.sv
// top level of the hue preserving rgb tone curve
//
// channel | dir | tdata (low bit up)                                   | tuser
// s_      | in  | red_in[17:0] green_in blue_in table_index table_value | req_type
// m_      | out | red_out[17:0] green_out blue_out (54 bits, pad to 56) | passed_through
//
// one transfer per cycle in both directions unless m_ stalls; pipeline stages in order:
// clamp/order, table read, difference, product, 16 divider stages, add and output register
// the tone table has one write port and two read ports (hi and lo) used per cycle
// a stall on m_ freezes the whole pipeline; s_tready = !out_valid || m_tready
// aresetn (sync, low) clears valid bits only; table content is undefined until written
module rgb_tone_curve_hue_preserving #(
    parameter int unsigned TABLE_DEPTH = rgbtc_pkg::TableDepthDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // red_in, green_in, blue_in, table_index, table_value
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // red_out, green_out, blue_out, zero pad
    output logic        m_tuser    // passed_through
);
    import rgbtc_pkg::*;
    localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

    logic en;
    assign en = m_tready || !m_tvalid;
    assign s_tready = en;

    // input unpack
    logic signed [17:0] in_r, in_g, in_b;
    logic [15:0] t_idx, t_val;
    assign in_r  = s_tdata[17:0];
    assign in_g  = s_tdata[35:18];
    assign in_b  = s_tdata[53:36];
    assign t_idx = s_tdata[69:54];
    assign t_val = s_tdata[85:70];

    logic acc;
    assign acc = s_tvalid && s_tready;

    // tone table memory
    logic [15:0] mem [0:TABLE_DEPTH-1];
    always_ff @(posedge aclk) begin
        if (acc && s_tuser == ReqWrite && {16'd0, t_idx} < 32'(TABLE_DEPTH)) begin
            mem[t_idx[AddrW-1:0]] <= t_val;
        end
    end

    // stage 1: clamp and order
    function automatic logic [15:0] clampf(logic signed [17:0] v);
        if (v < 0) return 16'd0;
        if (v > 18'sd65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    logic [15:0] cr, cg, cb;
    order_t ord;
    assign cr = clampf(in_r);
    assign cg = clampf(in_g);
    assign cb = clampf(in_b);
    always_comb begin
        ord = '{hi_sel: 2'd0, mid_sel: 2'd1, lo_sel: 2'd2, direct: 1'b0};
        if (cr >= cg) begin
            if (cg > cb)      ord = '{2'd0, 2'd1, 2'd2, 1'b0};
            else if (cb > cr) ord = '{2'd2, 2'd0, 2'd1, 1'b0};
            else if (cb > cg) ord = '{2'd0, 2'd2, 2'd1, 1'b0};
            else              ord = '{2'd0, 2'd1, 2'd2, 1'b1};
        end else begin
            if (cr >= cb)     ord = '{2'd1, 2'd0, 2'd2, 1'b0};
            else if (cb > cg) ord = '{2'd2, 2'd1, 2'd0, 1'b0};
            else              ord = '{2'd1, 2'd2, 2'd0, 1'b0};
        end
    end

    function automatic logic [15:0] pick(logic [1:0] s, logic [15:0] a, logic [15:0] b,
                                         logic [15:0] c);
        unique case (s)
            2'd0:    return a;
            2'd1:    return b;
            default: return c;
        endcase
    endfunction

    function automatic logic [AddrW-1:0] addr(logic [15:0] v);
        if ({16'd0, v} >= 32'(TABLE_DEPTH)) return AddrW'(TABLE_DEPTH - 1);
        return v[AddrW-1:0];
    endfunction

    logic        v1_reg;
    order_t      ord1_reg;
    logic [15:0] h1_reg, m1_reg, l1_reg;
    logic        pt1_reg;
    rgb_t        raw1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en) v1_reg <= acc && s_tuser == ReqPixel;
        if (en) begin
            ord1_reg <= ord;
            h1_reg   <= pick(ord.hi_sel, cr, cg, cb);
            m1_reg   <= pick(ord.mid_sel, cr, cg, cb);
            l1_reg   <= pick(ord.lo_sel, cr, cg, cb);
            pt1_reg  <= (in_r < 0 || in_r > 18'sd65535) && (in_g < 0 || in_g > 18'sd65535)
                        && (in_b < 0 || in_b > 18'sd65535);
            raw1_reg <= '{in_r, in_g, in_b};
        end
    end

    // stage 2: two table reads (hi and lo), registered data
    logic        v2_reg;
    order_t      ord2_reg;
    logic [15:0] h2_reg, m2_reg, l2_reg, th_reg, tl_reg;
    logic        pt2_reg;
    rgb_t        raw2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
        if (en) begin
            ord2_reg <= ord1_reg; h2_reg <= h1_reg; m2_reg <= m1_reg; l2_reg <= l1_reg;
            pt2_reg  <= pt1_reg;  raw2_reg <= raw1_reg;
            th_reg   <= mem[addr(h1_reg)];
            tl_reg   <= mem[addr(l1_reg)];
        end
    end

    // stage 3: differences; direct case uses the lo read as mid (equal values)
    logic        v3_reg;
    order_t      ord3_reg;
    logic [15:0] th3_reg, tl3_reg, dh_reg, dm_reg, den3_reg;
    logic        pt3_reg;
    rgb_t        raw3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en) v3_reg <= v2_reg;
        if (en) begin
            ord3_reg <= ord2_reg; pt3_reg <= pt2_reg; raw3_reg <= raw2_reg;
            th3_reg  <= th_reg;   tl3_reg <= tl_reg;
            dm_reg   <= m2_reg - l2_reg;
            den3_reg <= (h2_reg == l2_reg) ? 16'd1 : h2_reg - l2_reg;
            dh_reg   <= th_reg - tl_reg;
        end
    end

    // stage 4: product magnitude and sign
    logic        v4_reg;
    order_t      ord4_reg;
    logic [15:0] th4_reg, tl4_reg, den4_reg;
    logic [31:0] prod_reg;
    logic        neg4_reg, pt4_reg;
    rgb_t        raw4_reg;
    logic [15:0] dh_abs;
    assign dh_abs = (th3_reg >= tl3_reg) ? dh_reg : tl3_reg - th3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en) v4_reg <= v3_reg;
        if (en) begin
            ord4_reg <= ord3_reg; pt4_reg <= pt3_reg; raw4_reg <= raw3_reg;
            th4_reg  <= th3_reg;  tl4_reg <= tl3_reg; den4_reg <= den3_reg;
            prod_reg <= dh_abs * dm_reg;
            neg4_reg <= th3_reg < tl3_reg;
        end
    end

    // divider stages, side data delayed alongside
    logic [15:0] quot;
    rgbtc_div u_div (.aclk(aclk), .en(en), .num(prod_reg), .den(den4_reg), .quot(quot));

    typedef struct packed {
        logic        v;
        order_t      ord;
        logic [15:0] th;
        logic [15:0] tl;
        logic        neg;
        logic        pt;
        rgb_t        raw;
    } side_t;
    side_t side_reg [0:QuotWidth];
    always_comb side_reg[0] = '{v4_reg, ord4_reg, th4_reg, tl4_reg, neg4_reg, pt4_reg,
                                raw4_reg};
    for (genvar i = 0; i < QuotWidth; i++) begin : g_side
        always_ff @(posedge aclk) begin
            if (!aresetn) side_reg[i+1].v <= 1'b0;
            else if (en) side_reg[i+1].v <= side_reg[i].v;
            if (en) begin
                side_reg[i+1].ord <= side_reg[i].ord;
                side_reg[i+1].th  <= side_reg[i].th;
                side_reg[i+1].tl  <= side_reg[i].tl;
                side_reg[i+1].neg <= side_reg[i].neg;
                side_reg[i+1].pt  <= side_reg[i].pt;
                side_reg[i+1].raw <= side_reg[i].raw;
            end
        end
    end

    // final stage: add, place channels, output register
    side_t       sd;
    logic [15:0] mid_val;
    logic [17:0] ho, mo, lo, ro, go, bo;
    assign sd = side_reg[QuotWidth];
    assign mid_val = sd.ord.direct ? sd.tl : (sd.neg ? sd.tl - quot : sd.tl + quot);
    assign ho = {2'b00, sd.th};
    assign mo = {2'b00, mid_val};
    assign lo = {2'b00, sd.tl};
    always_comb begin
        ro = ho; go = mo; bo = lo;
        unique case (sd.ord.hi_sel)
            2'd0: ro = ho; 2'd1: go = ho; default: bo = ho;
        endcase
        unique case (sd.ord.mid_sel)
            2'd0: ro = mo; 2'd1: go = mo; default: bo = mo;
        endcase
        unique case (sd.ord.lo_sel)
            2'd0: ro = lo; 2'd1: go = lo; default: bo = lo;
        endcase
    end

    logic        out_valid_reg;
    rgb_t        out_reg;
    logic        out_pt_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (en) out_valid_reg <= sd.v;
        if (en) begin
            out_pt_reg <= sd.pt;
            out_reg    <= sd.pt ? sd.raw : '{ro, go, bo};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_pt_reg;
    assign m_tdata  = {2'b00, out_reg.blue, out_reg.green, out_reg.red};

    // checks
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && m_tvalid)
        else $error("output changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (m_tready || !m_tvalid))
        else $error("ready mismatch");
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == ReqWrite |=> !v1_reg)
        else $error("write produced a result");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[17:16] == 2'b00 && m_tdata[35:34] == 2'b00)
        else $error("toned value out of range");
endmodule
